### rtl/rect_overlap_suppressor_macros.svh
`ifndef RECT_OVERLAP_SUPPRESSOR_MACROS_SVH
`define RECT_OVERLAP_SUPPRESSOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ROS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ROS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ros_pkg.sv
package ros_pkg;

  localparam int MaxRefs   = 16;
  localparam int CoordBits = 12;
  localparam int EdgeBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * EdgeBits;

  typedef logic [1:0]           mode_t;
  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [EdgeBits-1:0]  edge_t;
  typedef logic [ProdBits-1:0]  prod_t;

  localparam mode_t MODE_CLEAR = 2'd0;
  localparam mode_t MODE_ADD   = 2'd1;
  localparam mode_t MODE_QUERY = 2'd2;

  typedef struct packed {
    mode_t  mode;
    coord_t rect_x;
    coord_t rect_y;
    coord_t rect_width;
    coord_t rect_height;
  } in_t;

  typedef struct packed {
    logic   keep;
    coord_t out_x;
    coord_t out_y;
    coord_t out_width;
    coord_t out_height;
    logic   ref_overflow;
  } out_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic start;
    logic issue;
    logic load_out;
  } cmd_t;

endpackage

### rtl/ros_datapath.sv
module ros_datapath #(
  parameter int MAX_REFS = ros_pkg::MaxRefs,
  parameter int CNT_W    = $clog2(MAX_REFS + 1),
  parameter int IDX_W    = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ros_pkg::in_t     in_data,
  input  ros_pkg::cmd_t    cmd,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [CNT_W-1:0] count,
  output logic             pipe_busy,
  output ros_pkg::out_t    out_data
);
  import ros_pkg::*;

  rect_t            mem [MAX_REFS];
  rect_t            in_rect;
  rect_t            q_r;
  rect_t            ref_r;
  logic [CNT_W-1:0] count_r;
  logic             ovf_r;
  logic             v0_r, v1_r, v2_r;
  logic             hit_r;
  edge_t            dx_r, dy_r, bx_r, by_r;
  logic             ok1_r, ok2_r;
  prod_t            inter_r, bnd_r;
  out_t             out_r;

  edge_t  qx2, qy2, rx2, ry2, hi_x, hi_y, top_x, top_y;
  coord_t lo_x, lo_y, bot_x, bot_y;
  logic   ix_ok, iy_ok, nonempty, room;

  assign in_rect = '{x: in_data.rect_x, y: in_data.rect_y,
                     w: in_data.rect_width, h: in_data.rect_height};
  assign room    = count_r < CNT_W'(MAX_REFS);

  always_comb begin
    qx2      = EdgeBits'(q_r.x) + EdgeBits'(q_r.w);
    qy2      = EdgeBits'(q_r.y) + EdgeBits'(q_r.h);
    rx2      = EdgeBits'(ref_r.x) + EdgeBits'(ref_r.w);
    ry2      = EdgeBits'(ref_r.y) + EdgeBits'(ref_r.h);
    lo_x     = (q_r.x > ref_r.x) ? q_r.x : ref_r.x;
    lo_y     = (q_r.y > ref_r.y) ? q_r.y : ref_r.y;
    bot_x    = (q_r.x < ref_r.x) ? q_r.x : ref_r.x;
    bot_y    = (q_r.y < ref_r.y) ? q_r.y : ref_r.y;
    hi_x     = (qx2 < rx2) ? qx2 : rx2;
    hi_y     = (qy2 < ry2) ? qy2 : ry2;
    top_x    = (qx2 > rx2) ? qx2 : rx2;
    top_y    = (qy2 > ry2) ? qy2 : ry2;
    ix_ok    = hi_x > EdgeBits'(lo_x);
    iy_ok    = hi_y > EdgeBits'(lo_y);
    nonempty = (q_r.w != '0) && (q_r.h != '0) && (ref_r.w != '0) && (ref_r.h != '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.add && room) begin
      mem[count_r[IDX_W-1:0]] <= in_rect;
    end
    ref_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      v0_r <= cmd.issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
      if (cmd.clear) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (cmd.add) begin
        if (room) begin
          count_r <= count_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.start) begin
        hit_r <= 1'b0;
      end else if (v2_r && ok2_r && (bnd_r != '0) &&
                   ({inter_r, 1'b0} > {1'b0, bnd_r})) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_r <= in_rect;
    end
    if (v0_r) begin
      dx_r  <= hi_x - EdgeBits'(lo_x);
      dy_r  <= hi_y - EdgeBits'(lo_y);
      bx_r  <= top_x - EdgeBits'(bot_x);
      by_r  <= top_y - EdgeBits'(bot_y);
      ok1_r <= nonempty && ix_ok && iy_ok;
    end
    if (v1_r) begin
      inter_r <= ProdBits'(dx_r) * ProdBits'(dy_r);
      bnd_r   <= ProdBits'(bx_r) * ProdBits'(by_r);
      ok2_r   <= ok1_r;
    end
    if (cmd.load_out) begin
      out_r <= '{keep: !hit_r, out_x: q_r.x, out_y: q_r.y,
                 out_width: q_r.w, out_height: q_r.h, ref_overflow: ovf_r};
    end
  end

  assign count     = count_r;
  assign pipe_busy = v0_r | v1_r | v2_r;
  assign out_data  = out_r;

endmodule

### rtl/ros_ctrl.sv
module ros_ctrl #(
  parameter int CNT_W = $clog2(ros_pkg::MaxRefs + 1),
  parameter int IDX_W = (ros_pkg::MaxRefs > 1) ? $clog2(ros_pkg::MaxRefs) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ros_pkg::mode_t   in_mode,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic [CNT_W-1:0] count,
  input  logic             pipe_busy,
  output ros_pkg::cmd_t    cmd,
  output logic [IDX_W-1:0] rd_idx
);
  import ros_pkg::*;

  typedef enum logic [1:0] {IDLE, SCAN, DRAIN, EMIT} state_t;

  state_t           state_r;
  logic [CNT_W-1:0] idx_r;
  logic             out_valid_r;
  logic             in_acc;
  logic             more;

  assign in_ready     = state_r == IDLE;
  assign in_acc       = in_valid && in_ready;
  assign more         = idx_r < count;
  assign cmd.clear    = in_acc && (in_mode == MODE_CLEAR);
  assign cmd.add      = in_acc && (in_mode == MODE_ADD);
  assign cmd.start    = in_acc && (in_mode == MODE_QUERY);
  assign cmd.issue    = (state_r == SCAN) && more;
  assign cmd.load_out = (state_r == EMIT) && (!out_valid_r || out_ready);
  assign rd_idx       = idx_r[IDX_W-1:0];
  assign out_valid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (cmd.start) begin
            state_r <= SCAN;
            idx_r   <= '0;
          end
        end
        SCAN: begin
          if (more) begin
            idx_r <= idx_r + CNT_W'(1);
          end else begin
            state_r <= DRAIN;
          end
        end
        DRAIN: begin
          if (!pipe_busy) begin
            state_r <= EMIT;
          end
        end
        EMIT: begin
          if (cmd.load_out) begin
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

endmodule

### rtl/rect_overlap_suppressor.sv
// Overlap suppressor for rectangles against a stored reference set.
// Input channel in_valid/in_ready/in_data carries one transaction per item:
//   mode clear empties the set and the overflow flag, mode add stores a
//   reference (dropped with a sticky overflow flag when full), mode query
//   tests the rectangle against every stored reference. The unused mode is
//   taken and ignored.
// Output channel out_valid/out_ready/out_data carries one transaction per
//   query: keep, the echoed rectangle and the overflow flag.
// Clear and add leave in_ready high. A query holds in_ready low from
//   acceptance until its result is loaded into the output register;
//   in_ready returns in that same cycle. The scan reads one reference per
//   cycle from the reference memory through a four-stage compare pipe
//   (read, edges, multiply, compare).
// A finished result sits in the output register; new items are accepted
//   while it waits. A further query stalls in its last step until the
//   receiver takes the previous result.
// Reset (rst_n low, synchronous) empties the set, clears the overflow flag
//   and drops any pending result. No clearing pass is needed.
module rect_overlap_suppressor #(
  parameter int MAX_REFS = ros_pkg::MaxRefs
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ros_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ros_pkg::out_t out_data
);
  import ros_pkg::*;

  localparam int CNT_W = $clog2(MAX_REFS + 1);
  localparam int IDX_W = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;

  cmd_t             cmd;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] count;
  logic             pipe_busy;

  ros_ctrl #(
    .CNT_W(CNT_W),
    .IDX_W(IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_data.mode),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .count    (count),
    .pipe_busy(pipe_busy),
    .cmd      (cmd),
    .rd_idx   (rd_idx)
  );

  ros_datapath #(
    .MAX_REFS(MAX_REFS),
    .CNT_W   (CNT_W),
    .IDX_W   (IDX_W)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .rd_idx   (rd_idx),
    .count    (count),
    .pipe_busy(pipe_busy),
    .out_data (out_data)
  );

endmodule

### rtl/ros_checker.sv
`include "rect_overlap_suppressor_macros.svh"

module ros_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input ros_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input ros_pkg::out_t out_data
);
  import ros_pkg::*;

  logic in_acc;
  logic out_stall;
  logic is_query;
  logic is_empty;

  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;
  assign is_query  = in_data.mode == MODE_QUERY;
  assign is_empty  = (out_data.out_width == '0) || (out_data.out_height == '0);

  `ROS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "result moved on stall")

  `ROS_ASSERT_NEXT(a_query_busy, in_acc && is_query, !in_ready, "input taken during a query scan")

  `ROS_ASSERT_NEXT(a_no_spurious, in_acc && !is_query && !out_valid, !out_valid, "stray result")

  `ROS_ASSERT_NOW(a_empty_kept, out_valid && is_empty, out_data.keep, "empty query suppressed")

endmodule

bind rect_overlap_suppressor ros_checker u_ros_checker (.*);

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ros_pkg::*;

  localparam mode_t MODE_UNUSED = 2'd3;
  localparam int StimItems = 600;
  localparam int CalmTail = 80;
  localparam int StallLimit = 5000;
  localparam int TailCycles = 40;

  typedef struct {
    in_t item;
    bit  drain;
  } pending_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  pending_t    stim_q[$];
  out_t        verdicts_due[$];
  rect_t       refs_held[MaxRefs];
  int unsigned refs_count = 0;
  bit          refs_dropped = 1'b0;
  int          mismatches = 0;
  int          queries_seen = 0;
  int          suppressed_seen = 0;
  int          overflow_seen = 0;
  int          items_queued = 0;
  int          idle_cycles = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  bit          in_took = 1'b0;

  rect_overlap_suppressor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // bounding box as the union; strict 2*inter > bound
  function automatic bit beyond_half(rect_t q, rect_t r);
    edge_t q_r, q_b, r_r, r_b, lo_x, lo_y, hi_x, hi_y, span_x, span_y;
    prod_t inter, bound;
    if (q.w == 0 || q.h == 0 || r.w == 0 || r.h == 0) return 1'b0;
    q_r = edge_t'(q.x) + edge_t'(q.w);
    q_b = edge_t'(q.y) + edge_t'(q.h);
    r_r = edge_t'(r.x) + edge_t'(r.w);
    r_b = edge_t'(r.y) + edge_t'(r.h);
    lo_x = edge_t'((q.x > r.x) ? q.x : r.x);
    lo_y = edge_t'((q.y > r.y) ? q.y : r.y);
    hi_x = (q_r < r_r) ? q_r : r_r;
    hi_y = (q_b < r_b) ? q_b : r_b;
    if (hi_x <= lo_x || hi_y <= lo_y) return 1'b0;
    span_x = ((q_r > r_r) ? q_r : r_r) - edge_t'((q.x < r.x) ? q.x : r.x);
    span_y = ((q_b > r_b) ? q_b : r_b) - edge_t'((q.y < r.y) ? q.y : r.y);
    inter = prod_t'(hi_x - lo_x) * prod_t'(hi_y - lo_y);
    bound = prod_t'(span_x) * prod_t'(span_y);
    return bound != 0 && {inter, 1'b0} > {1'b0, bound};
  endfunction

  function automatic void track_item(in_t t);
    rect_t b;
    out_t  v;
    b = '{t.rect_x, t.rect_y, t.rect_width, t.rect_height};
    case (t.mode)
      MODE_CLEAR: begin
        refs_count = 0;
        refs_dropped = 1'b0;
      end
      MODE_ADD: begin
        if (refs_count < MaxRefs) begin
          refs_held[refs_count] = b;
          refs_count++;
        end else begin
          refs_dropped = 1'b1;
        end
      end
      MODE_QUERY: begin
        v.keep = 1'b1;
        for (int i = 0; i < refs_count; i++)
          if (beyond_half(b, refs_held[i])) v.keep = 1'b0;
        v.out_x = b.x;
        v.out_y = b.y;
        v.out_width = b.w;
        v.out_height = b.h;
        v.ref_overflow = refs_dropped;
        verdicts_due.insert(verdicts_due.size(), v);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_result(out_t got);
    out_t want;
    if (verdicts_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: keep %b rect %0d,%0d,%0d,%0d overflow %b", got.keep,
                 got.out_x, got.out_y, got.out_width, got.out_height, got.ref_overflow);
      return;
    end
    want = verdicts_due.pop_front();
    queries_seen++;
    if (!want.keep) suppressed_seen++;
    if (want.ref_overflow) overflow_seen++;
    if (got.keep !== want.keep || got.out_x !== want.out_x || got.out_y !== want.out_y ||
        got.out_width !== want.out_width || got.out_height !== want.out_height ||
        got.ref_overflow !== want.ref_overflow) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"result %0d (exp/act): keep %b/%b x %0d/%0d y %0d/%0d",
                  " w %0d/%0d h %0d/%0d ovf %b/%b"},
                 queries_seen, want.keep, got.keep, want.out_x, got.out_x, want.out_y,
                 got.out_y, want.out_width, got.out_width, want.out_height, got.out_height,
                 want.ref_overflow, got.ref_overflow);
    end
  endfunction

  function automatic void push_item(mode_t m, rect_t r, bit drain);
    pending_t p;
    p.item = '{m, r.x, r.y, r.w, r.h};
    p.drain = drain;
    stim_q.insert(stim_q.size(), p);
    if (m != MODE_UNUSED) items_queued++;
  endfunction

  function automatic rect_t some_rect();
    rect_t r;
    r.x = coord_t'($urandom);
    r.y = coord_t'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      r.w = coord_t'($urandom);
      r.h = coord_t'($urandom);
    end else begin
      r.w = coord_t'($urandom_range(0, 48));
      r.h = coord_t'($urandom_range(0, 48));
    end
    return r;
  endfunction

  function automatic rect_t near_rect(rect_t r);
    rect_t q;
    q.x = r.x + coord_t'($urandom_range(0, 8)) - coord_t'($urandom_range(0, 8));
    q.y = r.y + coord_t'($urandom_range(0, 8)) - coord_t'($urandom_range(0, 8));
    q.w = r.w + coord_t'($urandom_range(0, 6)) - coord_t'($urandom_range(0, 6));
    q.h = r.h + coord_t'($urandom_range(0, 6)) - coord_t'($urandom_range(0, 6));
    return q;
  endfunction

  initial begin
    rect_t r, frame;
    int    n_add, n_query;
    rect_t added[$];
    frame = rect_t'{12'd0, 12'd0, 12'd4095, 12'd4095};

    push_item(MODE_QUERY, frame, 1'b0);
    push_item(MODE_ADD, frame, 1'b0);
    push_item(MODE_QUERY, frame, 1'b0);
    push_item(MODE_QUERY, rect_t'{12'd0, 12'd0, 12'd0, 12'd4095}, 1'b0);
    push_item(MODE_QUERY, rect_t'{12'd0, 12'd0, 12'd4095, 12'd0}, 1'b0);
    push_item(MODE_QUERY, rect_t'{12'd4095, 12'd4095, 12'd4095, 12'd4095}, 1'b0);
    push_item(MODE_UNUSED, frame, 1'b0);
    push_item(MODE_QUERY, rect_t'{12'd1, 12'd1, 12'd4094, 12'd4094}, 1'b0);
    push_item(MODE_CLEAR, frame, 1'b1);
    push_item(MODE_ADD, rect_t'{12'd0, 12'd0, 12'd2, 12'd1}, 1'b0);
    // exactly half stays, two thirds goes
    push_item(MODE_QUERY, rect_t'{12'd0, 12'd0, 12'd1, 12'd1}, 1'b0);
    push_item(MODE_QUERY, rect_t'{12'd0, 12'd0, 12'd3, 12'd1}, 1'b0);
    repeat (MaxRefs - 1) push_item(MODE_ADD, some_rect(), 1'b0);
    push_item(MODE_ADD, frame, 1'b0);
    push_item(MODE_QUERY, rect_t'{12'd0, 12'd0, 12'd2, 12'd1}, 1'b0);
    push_item(MODE_CLEAR, frame, 1'b0);
    push_item(MODE_QUERY, frame, 1'b0);

    while (items_queued < StimItems) begin
      if ($urandom_range(0, 4) != 0)
        push_item(MODE_CLEAR, some_rect(), $urandom_range(0, 7) == 0);
      added.delete();
      n_add = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 16);
      repeat (n_add) begin
        r = some_rect();
        added.insert(added.size(), r);
        push_item(MODE_ADD, r, 1'b0);
      end
      n_query = $urandom_range(2, 8);
      repeat (n_query) begin
        if (added.size() != 0 && $urandom_range(0, 2) != 0)
          r = near_rect(added[$urandom_range(0, added.size() - 1)]);
        else
          r = some_rect();
        push_item(MODE_QUERY, r, 1'b0);
      end
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4)) push_item(mode_t'($urandom), some_rect(), 1'b0);
    end

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_valid) @(negedge clk);
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);

    $display("checked %0d query results: %0d suppressed, %0d with overflow flagged",
             queries_seen, suppressed_seen, overflow_seen);
    $display("stimulus: %0d clear/add/query transactions plus ignored-mode noise",
             items_queued);
    if (mismatches == 0 && verdicts_due.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (stim_q.size() == 0 || (stim_q[0].drain && verdicts_due.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          in_data <= stim_q[0].item;
          in_valid <= 1'b1;
          void'(stim_q.pop_front());
          if (stim_q.size() > CalmTail && $urandom_range(0, 9) == 0)
            in_gap = $urandom_range(1, 19);
        end
      end
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap--;
      end else begin
        out_ready <= 1'b1;
        if (stim_q.size() > CalmTail && $urandom_range(0, 7) == 0)
          out_gap = $urandom_range(1, 19);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) track_item(in_data);
      if (out_valid && out_ready) check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("no transaction for %0d cycles", idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

### sim.f
+incdir+rtl
rtl/ros_pkg.sv
rtl/ros_datapath.sv
rtl/ros_ctrl.sv
rtl/rect_overlap_suppressor.sv
rtl/ros_checker.sv
sim/testbench.sv
